/* design/clt_pkg.sv */
// clt_pkg: shared types and codes for the calculator language tokenizer.
// Depends on nothing; used by clt_scan, clt_tokq and calc_language_tokenizer.
package clt_pkg;

	localparam int OFFSET_BITS_DEF = 32;
	localparam int LENGTH_BITS_DEF = 16;

	// token queue depth and pointer width
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [31:0] offset_t;
	typedef logic [15:0] length_t;

	typedef enum logic [3:0] {
		K_ASSIGN  = 4'd0,
		K_READ    = 4'd1,
		K_WRITE   = 4'd2,
		K_IDENT   = 4'd3,
		K_NUM     = 4'd4,
		K_NUMERR  = 4'd5,
		K_ADD     = 4'd6,
		K_MULT    = 4'd7,
		K_LPAR    = 4'd8,
		K_RPAR    = 4'd9,
		K_UNK     = 4'd10,
		K_EOF     = 4'd11
	} token_kind_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_input;
	} byte_t;

	typedef struct packed {
		token_kind_t token_kind;
		logic [7:0]  token_char;
		offset_t     token_start;
		length_t     token_length;
		logic        last_of_run;
	} token_t;

	// tokens produced by one input beat, in order
	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} push_t;

endpackage

/* design/clt_scan.sv */
// clt_scan: lexer state and per-byte token decision, one beat per cycle while take is high.
// Depends on clt_pkg; feeds up to two tokens per beat to clt_tokq.
module clt_scan #(
	parameter int OFFSET_BITS = clt_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = clt_pkg::LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           take,
	input  clt_pkg::byte_t byte_data,
	output clt_pkg::push_t push
);

	typedef enum logic [3:0] {
		M_IDLE,
		M_SLASH,
		M_COLON,
		M_KW,
		M_IDENT,
		M_INT,
		M_DOT,
		M_FRAC,
		M_CMT,
		M_CMT_STAR
	} mode_t;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_W     = 8'h77;

	mode_t                  mode_q, mode_d;
	logic [2:0]             match_q, match_d;
	logic [OFFSET_BITS-1:0] start_q, start_d;
	logic [LENGTH_BITS-1:0] len_q, len_d, len_g, pend_len;
	logic [OFFSET_BITS-1:0] off_q, off_d;
	logic [7:0]             lead_q, lead_d;

	logic [7:0]           c;
	logic                 is_letter, is_digit, is_word;
	logic                 f_begin, f_emit;
	mode_t                f_mode;
	clt_pkg::token_kind_t f_kind, pend_kind;
	logic                 pend, use_fresh, grow, rd;
	logic [2:0]           wlen;
	logic [7:0]           kw_exp;
	clt_pkg::token_t      pend_tok, fresh_tok, eof_tok, second_tok;
	logic                 has_second;

	function automatic logic [7:0] kw_char(input logic is_rd, input logic [2:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (is_rd) begin
			case (idx)
				3'd0: r = "r";
				3'd1: r = "e";
				3'd2: r = "a";
				3'd3: r = "d";
				default: r = 8'h00;
			endcase
		end else begin
			case (idx)
				3'd0: r = "w";
				3'd1: r = "r";
				3'd2: r = "i";
				3'd3: r = "t";
				3'd4: r = "e";
				default: r = 8'h00;
			endcase
		end
		return r;
	endfunction

	assign c         = byte_data.char_code;
	assign is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	assign is_digit  = (c >= "0" && c <= "9");
	assign is_word   = is_letter || is_digit || (c == CH_UNDER);
	assign len_g     = (&len_q) ? len_q : len_q + LENGTH_BITS'(1);
	assign rd        = (lead_q == CH_R);
	assign wlen      = rd ? 3'd4 : 3'd5;
	assign kw_exp    = kw_char(rd, match_q);

	// classification of a byte where a token may start
	always_comb begin
		f_begin = 1'b0;
		f_emit  = 1'b0;
		f_mode  = M_IDLE;
		f_kind  = clt_pkg::K_UNK;
		if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
			f_mode = M_IDLE;
		end else if (c == CH_SLASH) begin
			f_begin = 1'b1;
			f_mode  = M_SLASH;
		end else if (c == CH_COLON) begin
			f_begin = 1'b1;
			f_mode  = M_COLON;
		end else if (c == CH_R || c == CH_W) begin
			f_begin = 1'b1;
			f_mode  = M_KW;
		end else if (is_letter || c == CH_UNDER) begin
			f_begin = 1'b1;
			f_mode  = M_IDENT;
		end else if (is_digit) begin
			f_begin = 1'b1;
			f_mode  = M_INT;
		end else begin
			f_emit = 1'b1;
			case (c)
				CH_PLUS, CH_MINUS: f_kind = clt_pkg::K_ADD;
				CH_STAR:           f_kind = clt_pkg::K_MULT;
				CH_LPAR:           f_kind = clt_pkg::K_LPAR;
				CH_RPAR:           f_kind = clt_pkg::K_RPAR;
				default:           f_kind = clt_pkg::K_UNK;
			endcase
		end
	end

	always_comb begin
		mode_d    = mode_q;
		match_d   = match_q;
		start_d   = start_q;
		len_d     = len_q;
		lead_d    = lead_q;
		off_d     = off_q;
		pend      = 1'b0;
		pend_kind = clt_pkg::K_IDENT;
		use_fresh = 1'b0;
		grow      = 1'b0;
		if (byte_data.end_of_input) begin
			mode_d = M_IDLE;
			case (mode_q)
				M_SLASH: begin
					pend = 1'b1;
					pend_kind = clt_pkg::K_MULT;
				end
				M_COLON: begin
					pend = 1'b1;
					pend_kind = clt_pkg::K_UNK;
				end
				M_KW, M_IDENT: begin
					pend = 1'b1;
					pend_kind = clt_pkg::K_IDENT;
				end
				M_INT, M_FRAC: begin
					pend = 1'b1;
					pend_kind = clt_pkg::K_NUM;
				end
				M_DOT: begin
					pend = 1'b1;
					pend_kind = clt_pkg::K_NUMERR;
				end
				default: pend = 1'b0;
			endcase
		end else begin
			off_d = off_q + OFFSET_BITS'(1);
			case (mode_q)
				M_SLASH: begin
					if (c == CH_STAR) begin
						mode_d = M_CMT;
					end else begin
						pend = 1'b1;
						pend_kind = clt_pkg::K_MULT;
						use_fresh = 1'b1;
					end
				end
				M_COLON: begin
					pend = 1'b1;
					if (c == CH_EQ) begin
						grow = 1'b1;
						pend_kind = clt_pkg::K_ASSIGN;
					end else begin
						pend_kind = clt_pkg::K_UNK;
						use_fresh = 1'b1;
					end
				end
				M_KW: begin
					if (match_q < wlen && c == kw_exp) begin
						match_d = match_q + 3'd1;
						grow = 1'b1;
						if (match_q + 3'd1 == wlen) begin
							pend = 1'b1;
							pend_kind = rd ? clt_pkg::K_READ : clt_pkg::K_WRITE;
						end
					end else if (is_word) begin
						mode_d = M_IDENT;
						grow = 1'b1;
					end else begin
						pend = 1'b1;
						pend_kind = clt_pkg::K_IDENT;
						use_fresh = 1'b1;
					end
				end
				M_IDENT: begin
					if (is_word) begin
						grow = 1'b1;
					end else begin
						pend = 1'b1;
						pend_kind = clt_pkg::K_IDENT;
						use_fresh = 1'b1;
					end
				end
				M_INT: begin
					if (is_digit) begin
						grow = 1'b1;
					end else if (c == CH_DOT) begin
						mode_d = M_DOT;
						grow = 1'b1;
					end else begin
						pend = 1'b1;
						pend_kind = clt_pkg::K_NUM;
						use_fresh = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit) begin
						mode_d = M_FRAC;
						grow = 1'b1;
					end else begin
						// byte after a dangling dot is swallowed
						pend = 1'b1;
						pend_kind = clt_pkg::K_NUMERR;
					end
				end
				M_FRAC: begin
					if (is_digit) begin
						grow = 1'b1;
					end else begin
						pend = 1'b1;
						pend_kind = clt_pkg::K_NUM;
						use_fresh = 1'b1;
					end
				end
				M_CMT: begin
					if (c == CH_NL)
						mode_d = M_IDLE;
					else if (c == CH_STAR)
						mode_d = M_CMT_STAR;
				end
				M_CMT_STAR: begin
					if (c == CH_SLASH || c == CH_NL)
						mode_d = M_IDLE;
					else if (c != CH_STAR)
						mode_d = M_CMT;
				end
				default: use_fresh = 1'b1;
			endcase
			if (grow)
				len_d = len_g;
			if (pend)
				mode_d = M_IDLE;
			if (use_fresh) begin
				mode_d = f_mode;
				if (f_begin) begin
					start_d = off_q;
					lead_d  = c;
					len_d   = LENGTH_BITS'(1);
					match_d = 3'd1;
				end
			end
		end
	end

	assign pend_len = grow ? len_g : len_q;

	always_comb begin
		pend_tok.token_kind   = pend_kind;
		pend_tok.token_char   = lead_q;
		pend_tok.token_start  = clt_pkg::offset_t'(start_q);
		pend_tok.token_length = clt_pkg::length_t'(pend_len);
		pend_tok.last_of_run  = 1'b0;

		fresh_tok.token_kind   = f_kind;
		fresh_tok.token_char   = c;
		fresh_tok.token_start  = clt_pkg::offset_t'(off_q);
		fresh_tok.token_length = clt_pkg::length_t'(1);
		fresh_tok.last_of_run  = 1'b0;

		eof_tok.token_kind   = clt_pkg::K_EOF;
		eof_tok.token_char   = 8'h00;
		eof_tok.token_start  = clt_pkg::offset_t'(off_q);
		eof_tok.token_length = '0;
		eof_tok.last_of_run  = 1'b0;

		second_tok = byte_data.end_of_input ? eof_tok : fresh_tok;
		has_second = byte_data.end_of_input || (use_fresh && f_emit);

		push.count  = {1'b0, pend} + {1'b0, has_second};
		push.first  = pend ? pend_tok : second_tok;
		push.second = second_tok;
		if (pend && has_second)
			push.second.last_of_run = 1'b1;
		else
			push.first.last_of_run = 1'b1;
		if (!take)
			push.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			match_q <= '0;
			start_q <= '0;
			len_q   <= '0;
			off_q   <= '0;
			lead_q  <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			match_q <= match_d;
			start_q <= start_d;
			len_q   <= len_d;
			off_q   <= off_d;
			lead_q  <= lead_d;
		end
	end

endmodule

/* design/clt_tokq.sv */
// clt_tokq: small token queue, takes up to two tokens a cycle, gives one while token_ready is high.
// Depends on clt_pkg; parts the lexer from the output channel.
module clt_tokq (
	input  logic            clk,
	input  logic            arst_n,
	input  clt_pkg::push_t  push,
	output logic            space_ok,
	output logic            token_valid,
	input  logic            token_ready,
	output clt_pkg::token_t token_data
);

	clt_pkg::token_t                mem [clt_pkg::QDEPTH];
	logic [clt_pkg::QPTR_W-1:0]     wptr_q, rptr_q, wptr_n;
	logic [clt_pkg::QCNT_W-1:0]     cnt_q;
	logic                           pop;

	assign token_valid = (cnt_q != '0);
	assign token_data  = mem[rptr_q];
	assign pop         = token_valid && token_ready;
	assign space_ok    = (cnt_q <= clt_pkg::QCNT_W'(clt_pkg::QDEPTH - 2));
	assign wptr_n      = wptr_q + clt_pkg::QPTR_W'(1);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wptr_q] <= push.first;
		if (push.count == 2'd2)
			mem[wptr_n] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + clt_pkg::QPTR_W'(push.count);
			if (pop)
				rptr_q <= rptr_q + clt_pkg::QPTR_W'(1);
			cnt_q <= cnt_q + clt_pkg::QCNT_W'(push.count) - clt_pkg::QCNT_W'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= clt_pkg::QCNT_W'(clt_pkg::QDEPTH))
		else $error("token queue overfilled");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> space_ok)
		else $error("tokens pushed without room");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd3)
		else $error("more than two tokens from one beat");
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count == 2'd2) |-> (push.second.last_of_run && !push.first.last_of_run))
		else $error("last_of_run misplaced on a two-token beat");
	a_eof_len: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_data.token_kind == clt_pkg::K_EOF)
			|-> (token_data.token_length == '0 && token_data.last_of_run))
		else $error("eof token malformed");
`endif

endmodule

/* design/calc_language_tokenizer.sv */
// calc_language_tokenizer: top level of the calculator language lexer.
// Depends on clt_pkg, clt_scan and clt_tokq.
//
//  channel  | valid       | ready       | payload                  | beat
//  ---------+-------------+-------------+--------------------------+-------------------
//  input    | byte_valid  | byte_ready  | byte_data  (byte_t)      | one byte or end
//  output   | token_valid | token_ready | token_data (token_t)     | one token
//
// One input beat per cycle while byte_ready is high; the lexer state updates at the edge that accepts it.
// A beat yields zero, one or two tokens, written into a four-entry token queue.
// Tokens leave one per cycle while token_ready is high, so the two tokens of one beat leave one after the other.
// byte_ready is high while the queue has room for two tokens.
// Reset clears the lexer to idle at offset zero and empties the queue.
module calc_language_tokenizer #(
	parameter int OFFSET_BITS = clt_pkg::OFFSET_BITS_DEF,
	parameter int LENGTH_BITS = clt_pkg::LENGTH_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            byte_valid,
	output logic            byte_ready,
	input  clt_pkg::byte_t  byte_data,
	output logic            token_valid,
	input  logic            token_ready,
	output clt_pkg::token_t token_data
);

	clt_pkg::push_t push;
	logic           space_ok;
	logic           take;

	assign byte_ready = space_ok;
	assign take       = byte_valid && space_ok;

	clt_scan #(
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.byte_data (byte_data),
		.push      (push)
	);

	clt_tokq u_tokq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.space_ok    (space_ok),
		.token_valid (token_valid),
		.token_ready (token_ready),
		.token_data  (token_data)
	);

endmodule
